[design/word_frequency_counter_defines.svh]
// Assertion macros shared by the word frequency counter modules.
`ifndef WORD_FREQUENCY_COUNTER_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define WFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfc check failed");

// Next-cycle implication checked outside reset.
`define WFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfc check failed");

`endif

[design/wfc_pkg.sv]
// Package with constants, types and helpers of the word frequency counter.
package wfc_pkg;
  localparam int MAX_WORD_CHARS = 19;
  localparam int TABLE_ENTRIES = 32;
  localparam int COUNT_BITS = 16;
  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int USED_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam int LEN_BITS = 5;
  localparam int WORD_BITS = 8 * MAX_WORD_CHARS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_END = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_char;      // append the input byte to the pending word
    logic search;        // register match results of the pending word
    logic commit;        // apply the registered lookup to the table
    logic load_out;      // load output register from entry list_idx
    logic load_empty;    // load the empty-table result
    logic clear;         // clear table, pending word and overflow flag
    logic [IDX_BITS-1:0] list_idx;
  } wfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending_nonzero;
    logic [USED_BITS-1:0] entries_used;
  } wfc_status_t;

  function automatic logic is_word_end(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_COMMA) || (c == CHAR_PERIOD) ||
           (c == CHAR_NEWLINE);
  endfunction
endpackage

[design/word_frequency_counter.sv]
// Word frequency counter: takes one text byte per beat and counts words.
// A plain byte beat is taken in idle; a word-ending byte with a pending word
// runs accept, parallel match over all 32 entries and table update. An
// end-of-text beat runs the same steps and then lists the entries one by
// one through the single output register, each held while stalled; the table
// is cleared after the last result beat is taken.
module word_frequency_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  entry_index,
  output logic [4:0]  word_length,
  output logic [63:0] word_chars_low,
  output logic [63:0] word_chars_mid,
  output logic [23:0] word_chars_high,
  output logic [15:0] word_count,
  output logic        table_overflowed,
  output logic        table_empty,
  output logic        last
);
  import wfc_pkg::*;

  wfc_cmd_t cmd;
  wfc_status_t status;

  // Sequencer.
  wfc_control u_control (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .text_byte(text_byte), .out_valid(out_valid),
    .out_stall(out_stall), .last(last), .status(status), .cmd(cmd)
  );

  // Table and output storage.
  wfc_datapath u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .text_byte(text_byte),
    .status(status), .entry_index(entry_index),
    .word_length(word_length), .word_chars_low(word_chars_low),
    .word_chars_mid(word_chars_mid), .word_chars_high(word_chars_high),
    .word_count(word_count), .table_overflowed(table_overflowed),
    .table_empty(table_empty)
  );
endmodule

[design/wfc_datapath.sv]
// Datapath: pending word, word table, parallel match and output register.
module wfc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  wfc_pkg::wfc_cmd_t         cmd,
  input  logic [7:0]                text_byte,
  output wfc_pkg::wfc_status_t      status,
  output logic [4:0]                entry_index,
  output logic [4:0]                word_length,
  output logic [63:0]               word_chars_low,
  output logic [63:0]               word_chars_mid,
  output logic [23:0]               word_chars_high,
  output logic [15:0]               word_count,
  output logic                      table_overflowed,
  output logic                      table_empty
);
  import wfc_pkg::*;

  logic [WORD_BITS-1:0] pending_word;
  logic [LEN_BITS-1:0] pending_length;
  logic [WORD_BITS-1:0] entry_word [TABLE_ENTRIES];
  logic [LEN_BITS-1:0] entry_length [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] entry_count [TABLE_ENTRIES];
  logic [USED_BITS-1:0] entries_used;
  logic overflow_seen;
  logic hit;
  logic [IDX_BITS-1:0] hit_idx;
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] match_next;
  logic [IDX_BITS-1:0] app_idx;

  // Compare the pending word with every valid entry at once.
  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      match_next[k] = (USED_BITS'(k) < entries_used) &&
                      (entry_length[k] == pending_length) &&
                      (entry_word[k] == pending_word);
    end
  end

  assign app_idx = entries_used[IDX_BITS-1:0];

  // Pending word and table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_length <= '0;
      entries_used <= '0;
      overflow_seen <= 1'b0;
      hit <= 1'b0;
      match <= '0;
    end else begin
      if (cmd.add_char && (pending_length < LEN_BITS'(MAX_WORD_CHARS))) begin
        pending_length <= pending_length + 1'b1;
      end
      if (cmd.search) begin
        match <= match_next;
        hit <= |match_next;
      end
      if (cmd.commit && (pending_length != '0)) begin
        pending_length <= '0;
        if (!hit) begin
          if (entries_used < USED_BITS'(TABLE_ENTRIES)) begin
            entries_used <= entries_used + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
      end
      if (cmd.clear) begin
        pending_length <= '0;
        entries_used <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // Encode the registered match vector; at most one bit is set.
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (match[k]) hit_idx = IDX_BITS'(k);
    end
  end

  // Character storage and table entries.
  always_ff @(posedge clk) begin
    if (cmd.add_char && (pending_length < LEN_BITS'(MAX_WORD_CHARS))) begin
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
        if (LEN_BITS'(i) == pending_length) pending_word[8*i +: 8] <= text_byte;
        else if (LEN_BITS'(i) > pending_length) pending_word[8*i +: 8] <= 8'h00;
      end
    end
    if (cmd.commit && (pending_length != '0)) begin
      if (hit) begin
        if (entry_count[hit_idx] != COUNT_MAX) begin
          entry_count[hit_idx] <= entry_count[hit_idx] + 1'b1;
        end
      end else if (entries_used < USED_BITS'(TABLE_ENTRIES)) begin
        entry_word[app_idx] <= pending_word;
        entry_length[app_idx] <= pending_length;
        entry_count[app_idx] <= COUNT_BITS'(1);
      end
    end
  end

  // Output register; holds while the beat is stalled.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entry_index <= 5'(cmd.list_idx);
      word_length <= entry_length[cmd.list_idx];
      word_chars_low <= 64'(entry_word[cmd.list_idx]);
      word_chars_mid <= 64'(entry_word[cmd.list_idx] >> 64);
      word_chars_high <= 24'(entry_word[cmd.list_idx] >> 128);
      word_count <= 16'(entry_count[cmd.list_idx]);
      table_overflowed <= overflow_seen;
      table_empty <= 1'b0;
    end else if (cmd.load_empty) begin
      entry_index <= '0;
      word_length <= '0;
      word_chars_low <= '0;
      word_chars_mid <= '0;
      word_chars_high <= '0;
      word_count <= '0;
      table_overflowed <= overflow_seen;
      table_empty <= 1'b1;
    end
  end

  assign status.pending_nonzero = (pending_length != '0);
  assign status.entries_used = entries_used;

  `include "word_frequency_counter_defines.svh"
  `WFC_ASSERT_IMP(a_onehot_match, 1'b1, $onehot0(match))
  `WFC_ASSERT_IMP(a_used_range, 1'b1, entries_used <= USED_BITS'(TABLE_ENTRIES))
  `WFC_ASSERT_NEXT(a_clear, cmd.clear, entries_used == '0 && !overflow_seen)
  `WFC_ASSERT_NEXT(a_commit_done, cmd.commit, pending_length == '0)
endmodule

[design/wfc_control.sv]
// Controller: sequences byte handling, word lookup and table listing.
module wfc_control (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [7:0]            text_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  last,
  input  wfc_pkg::wfc_status_t  status,
  output wfc_pkg::wfc_cmd_t     cmd
);
  import wfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_COMMIT, S_LIST, S_SHOW
  } state_t;

  state_t state;
  logic is_end;
  logic [IDX_BITS-1:0] list_idx;
  logic accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    cmd.list_idx = list_idx;
    unique case (state)
      S_IDLE: begin
        cmd.add_char = accept && (action == ACTION_BYTE) && (text_byte != CHAR_NUL) &&
                       !is_word_end(text_byte);
      end
      S_SEARCH: cmd.search = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_LIST: begin
        cmd.load_out = (status.entries_used != '0);
        cmd.load_empty = (status.entries_used == '0);
      end
      S_SHOW: cmd.clear = !out_stall && last;
      default: cmd = '0;
    endcase
  end

  // State register and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_end <= 1'b0;
      list_idx <= '0;
      out_valid <= 1'b0;
      last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_end <= (action == ACTION_END);
            if (action == ACTION_END) state <= S_SEARCH;
            else if (is_word_end(text_byte) && status.pending_nonzero) state <= S_SEARCH;
          end
        end
        S_SEARCH: state <= S_COMMIT;
        S_COMMIT: begin
          list_idx <= '0;
          state <= is_end ? S_LIST : S_IDLE;
        end
        S_LIST: begin
          out_valid <= 1'b1;
          last <= (status.entries_used == '0) ||
                  (USED_BITS'(list_idx) + 1'b1 == status.entries_used);
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            list_idx <= list_idx + 1'b1;
            state <= last ? S_IDLE : S_LIST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "word_frequency_counter_defines.svh"
  `WFC_ASSERT_IMP(a_valid_show, out_valid, state == S_SHOW)
  `WFC_ASSERT_IMP(a_stall_busy, state != S_IDLE, in_stall)
  `WFC_ASSERT_NEXT(a_list_next, state == S_LIST, out_valid)
endmodule

[sim/testbench.sv]
// Self-checking testbench of the word frequency counter.
`timescale 1ns / 1ps

// Holds the predicted word table and the queue of expected listing beats.
class word_table_board;
  typedef struct packed {
    logic [4:0]  idx;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [23:0] hi;
    logic [15:0] cnt;
    logic        ovf;
    logic        empty;
    logic        lst;
  } listing_t;

  logic [7:0]  word_buf [wfc_pkg::MAX_WORD_CHARS];
  int          word_len;
  logic [4:0]  tab_len [wfc_pkg::TABLE_ENTRIES];
  logic [63:0] tab_lo [wfc_pkg::TABLE_ENTRIES];
  logic [63:0] tab_mid [wfc_pkg::TABLE_ENTRIES];
  logic [23:0] tab_hi [wfc_pkg::TABLE_ENTRIES];
  logic [15:0] tab_cnt [wfc_pkg::TABLE_ENTRIES];
  int          used;
  logic        ovf_flag;
  listing_t    pending_listing [$];
  int          errors;
  int          listings_checked;

  function new();
    word_len = 0;
    used = 0;
    ovf_flag = 1'b0;
    errors = 0;
    listings_checked = 0;
  endfunction

  // Close the pending word: count a hit, append a miss or note overflow.
  function void close_word();
    logic [63:0] lo, mid;
    logic [23:0] hi;
    lo = '0;
    mid = '0;
    hi = '0;
    if (word_len == 0) return;
    for (int i = 0; i < word_len; i++) begin
      if (i < 8) lo[8*i +: 8] = word_buf[i];
      else if (i < 16) mid[8*(i-8) +: 8] = word_buf[i];
      else hi[8*(i-16) +: 8] = word_buf[i];
    end
    for (int k = 0; k < used; k++) begin
      if (tab_len[k] == word_len && tab_lo[k] == lo && tab_mid[k] == mid &&
          tab_hi[k] == hi) begin
        if (tab_cnt[k] != wfc_pkg::COUNT_MAX) tab_cnt[k]++;
        word_len = 0;
        return;
      end
    end
    if (used < wfc_pkg::TABLE_ENTRIES) begin
      tab_lo[used] = lo;
      tab_mid[used] = mid;
      tab_hi[used] = hi;
      tab_len[used] = 5'(word_len);
      tab_cnt[used] = 16'd1;
      used++;
    end else begin
      ovf_flag = 1'b1;
    end
    word_len = 0;
  endfunction

  // Note one accepted input beat.
  function void note_input(logic act, logic [7:0] c);
    listing_t r;
    if (act == wfc_pkg::ACTION_BYTE) begin
      if (c == wfc_pkg::CHAR_NUL) return;
      if (wfc_pkg::is_word_end(c)) close_word();
      else if (word_len < wfc_pkg::MAX_WORD_CHARS) begin
        word_buf[word_len] = c;
        word_len++;
      end
      return;
    end
    close_word();
    if (used == 0) begin
      r = '0;
      r.ovf = ovf_flag;
      r.empty = 1'b1;
      r.lst = 1'b1;
      pending_listing.push_back(r);
    end
    for (int k = 0; k < used; k++) begin
      r.idx = 5'(k);
      r.len = tab_len[k];
      r.lo = tab_lo[k];
      r.mid = tab_mid[k];
      r.hi = tab_hi[k];
      r.cnt = tab_cnt[k];
      r.ovf = ovf_flag;
      r.empty = 1'b0;
      r.lst = (k + 1 == used);
      pending_listing.push_back(r);
    end
    used = 0;
    ovf_flag = 1'b0;
    word_len = 0;
  endfunction

  // Compare one accepted result beat with the oldest expectation.
  function void check_result(listing_t got);
    listing_t e;
    if (pending_listing.size() == 0) begin
      $error("unexpected result beat, entry_index %0d", got.idx);
      errors++;
      return;
    end
    e = pending_listing.pop_front();
    listings_checked++;
    if (got.idx !== e.idx) begin
      $error("entry_index expected %0d actual %0d", e.idx, got.idx); errors++;
    end
    if (got.len !== e.len) begin
      $error("word_length expected %0d actual %0d", e.len, got.len); errors++;
    end
    if (got.lo !== e.lo) begin
      $error("word_chars_low expected %h actual %h", e.lo, got.lo); errors++;
    end
    if (got.mid !== e.mid) begin
      $error("word_chars_mid expected %h actual %h", e.mid, got.mid); errors++;
    end
    if (got.hi !== e.hi) begin
      $error("word_chars_high expected %h actual %h", e.hi, got.hi); errors++;
    end
    if (got.cnt !== e.cnt) begin
      $error("word_count expected %0d actual %0d", e.cnt, got.cnt); errors++;
    end
    if (got.ovf !== e.ovf) begin
      $error("table_overflowed expected %0d actual %0d", e.ovf, got.ovf); errors++;
    end
    if (got.empty !== e.empty) begin
      $error("table_empty expected %0d actual %0d", e.empty, got.empty); errors++;
    end
    if (got.lst !== e.lst) begin
      $error("last expected %0d actual %0d", e.lst, got.lst); errors++;
    end
  endfunction
endclass

module testbench;
  import wfc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  entry_index;
  logic [4:0]  word_length;
  logic [63:0] word_chars_low;
  logic [63:0] word_chars_mid;
  logic [23:0] word_chars_high;
  logic [15:0] word_count;
  logic        table_overflowed;
  logic        table_empty;
  logic        last;

  word_table_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int items_sent = 0;
  int listings_sent = 0;

  always #2 clk = ~clk;

  word_frequency_counter u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .text_byte(text_byte), .out_valid(out_valid),
    .out_stall(out_stall), .entry_index(entry_index), .word_length(word_length),
    .word_chars_low(word_chars_low), .word_chars_mid(word_chars_mid),
    .word_chars_high(word_chars_high), .word_count(word_count),
    .table_overflowed(table_overflowed), .table_empty(table_empty), .last(last)
  );

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_input(action, text_byte);
    if (!rst && out_valid && !out_stall)
      board.check_result({entry_index, word_length, word_chars_low,
                          word_chars_mid, word_chars_high, word_count,
                          table_overflowed, table_empty, last});
  end

  // Receiver stall, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Send one beat, with random idle cycles before it. Starts and ends at a
  // falling edge; valid stays high afterwards until the next beat or idle.
  task automatic send_beat(logic act, logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    text_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (act == ACTION_END) listings_sent++;
  endtask

  // Drop valid once the sender has nothing more to offer.
  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_word(string w, logic [7:0] sep);
    for (int i = 0; i < w.len(); i++) send_beat(ACTION_BYTE, w[i]);
    send_beat(ACTION_BYTE, sep);
  endtask

  // Word ending bytes, picked at random.
  function automatic logic [7:0] pick_sep();
    case ($urandom_range(3))
      0: return CHAR_SPACE;
      1: return CHAR_COMMA;
      2: return CHAR_PERIOD;
      default: return CHAR_NEWLINE;
    endcase
  endfunction

  // Random letter from a small alphabet so that words repeat often.
  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  task automatic wait_drained();
    while (board.pending_listing.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One random text of well-formed words mixed with noise bytes.
  task automatic random_text(int nbytes);
    int n;
    n = 0;
    while (n < nbytes) begin
      if ($urandom_range(9) == 0) begin
        send_beat(ACTION_BYTE, 8'($urandom));
        n++;
      end else begin
        int wl;
        wl = ($urandom_range(15) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 3);
        for (int i = 0; i < wl; i++) send_beat(ACTION_BYTE, pick_letter());
        send_beat(ACTION_BYTE, pick_sep());
        n += wl + 1;
      end
    end
    send_beat(ACTION_END, 8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty listing, separators, byte zero, long and high bytes.
    send_beat(ACTION_END, 8'hFF);
    send_word("hello", CHAR_SPACE);
    send_word("hello", CHAR_COMMA);
    send_beat(ACTION_BYTE, CHAR_NUL);
    send_word("abcdefghijklmnopqrstuvw", CHAR_PERIOD);
    send_beat(ACTION_BYTE, CHAR_NEWLINE);
    send_beat(ACTION_BYTE, 8'hFF);
    send_beat(ACTION_BYTE, 8'h01);
    send_beat(ACTION_END, 8'h00);
    release_input();
    wait_drained();

    // Directed: overfill the table, then end with a pending word.
    for (int k = 0; k < TABLE_ENTRIES + 2; k++) begin
      send_beat(ACTION_BYTE, 8'h41 + 8'(k));
      send_beat(ACTION_BYTE, CHAR_SPACE);
    end
    send_beat(ACTION_BYTE, 8'h41);
    send_beat(ACTION_END, 8'h00);
    release_input();
    wait_drained();
    send_beat(ACTION_END, 8'h00);

    // Long receiver hold-off while the sender keeps offering beats.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int r = 0; r < 3; r++) random_text(8);
        release_input();
      end
    join
    wait_drained();

    // Random phases with the two idling profiles and then none.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 12 : 0;
      for (int r = 0; r < 5; r++) random_text(10);
      release_input();
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d beats with %0d end-of-text listings; checked %0d result beats.",
             items_sent, listings_sent, board.listings_checked);
    $display("Covered empty tables, truncation, table overflow and stall pressure.");
    if (board.errors == 0 && board.pending_listing.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/wfc_pkg.sv
design/wfc_datapath.sv
design/wfc_control.sv
design/word_frequency_counter.sv
sim/testbench.sv
